// ----- sv/fenwick_range_add_range_sum_assert.svh -----
// ----------------------------------------------------------------------------
// Fenwick range-add/range-sum assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FENWICK_RANGE_ADD_RANGE_SUM_ASSERT_SVH
`define FENWICK_RANGE_ADD_RANGE_SUM_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FWK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define FWK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fwk_pkg.sv -----
// ----------------------------------------------------------------------------
// fwk_pkg
// Constants and beat types for the Fenwick range-add/range-sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwk_pkg;

    localparam int C_SIZE   = 1024;
    localparam int C_LAST   = C_SIZE - 1;
    localparam int C_IDX_W  = $clog2(C_SIZE);
    localparam int C_WALK_W = C_IDX_W + 1;
    localparam int C_DATA_W = 32;

    localparam logic C_REQ_ADD   = 1'b0;
    localparam logic C_REQ_QUERY = 1'b1;

    localparam logic C_STS_DONE = 1'b0;
    localparam logic C_STS_BAD  = 1'b1;

    typedef logic [C_IDX_W-1:0]  t_idx;
    typedef logic [C_WALK_W-1:0] t_walk;
    typedef logic [C_DATA_W-1:0] t_data;

    typedef struct packed {
        logic                       req_type;
        logic [9:0]                 left;
        logic [9:0]                 right;
        logic signed [31:0]         value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0]         range_sum;
        logic                       status;
    } t_out_beat;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_idx  raddr;
        t_data wdata;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- sv/fenwick_range_add_range_sum.sv -----
// ----------------------------------------------------------------------------
// fenwick_range_add_range_sum
// Range add and range sum over two Fenwick trees walked in parallel.
// ----------------------------------------------------------------------------
//  channel | valid      | stall       | beat
//  --------+------------+-------------+------------------------------------
//  in      | i_in_valid | o_in_stall  | i_in  : req_type, left, right, value
//  out     | o_out_valid| i_out_stall | o_out : range_sum, status
//
//  After reset a clearing pass writes zero to all 1024 entries of both
//  trees, one entry per cycle; o_in_stall is high until the pass ends.
//  One item at a time: an add walks both trees up from left, then from
//  right+1 unless right is the last entry; a query walks both down from
//  each end x (right, and left-1 when nonzero); bad ranges go straight out.
//  A result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fenwick_range_add_range_sum import fwk_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_beat o_out
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_AMUL = 4'd2;
    localparam logic [3:0] S_AUPD = 4'd3;
    localparam logic [3:0] S_QRD  = 4'd4;
    localparam logic [3:0] S_QACC = 4'd5;
    localparam logic [3:0] S_QMUL = 4'd6;
    localparam logic [3:0] S_QSUB = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state, n_state;
    t_idx       r_clr, n_clr;
    t_walk      r_idx, n_idx;
    logic       r_phase, n_phase;
    t_idx       r_lo, n_lo;
    t_idx       r_hi, n_hi;
    t_data      r_val, n_val;
    t_data      r_q1, n_q1;
    t_data      r_q2, n_q2;
    t_data      r_sum, n_sum;
    logic       r_bad, n_bad;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out, n_out;

    t_ram_req   req_d, req_w;
    t_data      rdata_d, rdata_w;
    t_data      prod;
    t_data      mul_a;
    logic       mul_en;

    t_walk      lsb;
    t_walk      up_nxt;
    t_walk      dn_nxt;
    t_walk      hi_p1;
    t_idx       lo_m1;
    t_idx       in_lo_m1;
    t_idx       rd_addr;
    logic       in_bad;
    logic       accept;
    t_data      delta_d, delta_w;
    t_data      part;

    fwk_ram u_ram_d (
        .i_clk   (i_clk),
        .i_req   (req_d),
        .o_rdata (rdata_d)
    );

    fwk_ram u_ram_w (
        .i_clk   (i_clk),
        .i_req   (req_w),
        .o_rdata (rdata_w)
    );

    fwk_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    ((r_state == S_QMUL) ? r_q1 : r_val),
        .o_prod (prod)
    );

    assign lsb      = r_idx & (~r_idx + t_walk'(1));
    assign up_nxt   = r_idx + lsb;
    assign dn_nxt   = r_idx - lsb;
    assign hi_p1    = {1'b0, r_hi} + t_walk'(1);
    assign lo_m1    = r_lo - t_idx'(1);
    assign in_lo_m1 = i_in.left - t_idx'(1);
    assign accept   = i_in_valid && !o_in_stall;
    assign in_bad   = (i_in.left == '0) || (i_in.left > i_in.right)
                   || ({1'b0, i_in.right} > t_walk'(C_LAST));
    assign mul_a    = r_phase ? {{(C_DATA_W-C_IDX_W){1'b0}}, r_hi}
                              : {{(C_DATA_W-C_IDX_W){1'b0}}, lo_m1};
    assign mul_en   = (r_state == S_AMUL) || (r_state == S_QMUL);
    assign delta_d  = r_phase ? (t_data'(0) - r_val) : r_val;
    assign delta_w  = r_phase ? (t_data'(0) - prod) : prod;
    assign part     = prod - r_q2;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        rd_addr = r_idx[C_IDX_W-1:0];
        if (r_state == S_AUPD && up_nxt < t_walk'(C_SIZE)) begin
            rd_addr = up_nxt[C_IDX_W-1:0];
        end else if (r_state == S_QACC && dn_nxt != '0) begin
            rd_addr = dn_nxt[C_IDX_W-1:0];
        end
    end

    always_comb begin
        req_d.we    = 1'b0;
        req_d.waddr = r_idx[C_IDX_W-1:0];
        req_d.raddr = rd_addr;
        req_d.wdata = rdata_d + delta_d;
        req_w.we    = 1'b0;
        req_w.waddr = r_idx[C_IDX_W-1:0];
        req_w.raddr = rd_addr;
        req_w.wdata = rdata_w + delta_w;
        if (r_state == S_CLR) begin
            req_d.we    = 1'b1;
            req_d.waddr = r_clr;
            req_d.wdata = '0;
            req_w.we    = 1'b1;
            req_w.waddr = r_clr;
            req_w.wdata = '0;
        end else if (r_state == S_AUPD) begin
            req_d.we = 1'b1;
            req_w.we = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_val       = r_val;
        n_q1        = r_q1;
        n_q2        = r_q2;
        n_sum       = r_sum;
        n_bad       = r_bad;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + t_idx'(1);
                if (r_clr == t_idx'(C_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_lo  = i_in.left;
                    n_hi  = i_in.right;
                    n_val = i_in.value;
                    n_sum = '0;
                    n_bad = in_bad;
                    if (in_bad) begin
                        n_state = S_DONE;
                    end else if (i_in.req_type == C_REQ_ADD) begin
                        n_phase = 1'b0;
                        n_idx   = {1'b0, i_in.left};
                        n_state = S_AMUL;
                    end else if (i_in.left == t_idx'(1)) begin
                        n_phase = 1'b1;
                        n_idx   = {1'b0, i_in.right};
                        n_state = S_QRD;
                    end else begin
                        n_phase = 1'b0;
                        n_idx   = {1'b0, in_lo_m1};
                        n_state = S_QRD;
                    end
                end
            end
            S_AMUL: begin
                n_state = S_AUPD;
            end
            S_AUPD: begin
                if (up_nxt < t_walk'(C_SIZE)) begin
                    n_idx = up_nxt;
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                    n_idx   = hi_p1;
                    n_state = (hi_p1 < t_walk'(C_SIZE)) ? S_AMUL : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QRD: begin
                n_q1    = '0;
                n_q2    = '0;
                n_state = S_QACC;
            end
            S_QACC: begin
                n_q1 = r_q1 + rdata_d;
                n_q2 = r_q2 + rdata_w;
                if (dn_nxt != '0) begin
                    n_idx = dn_nxt;
                end else begin
                    n_state = S_QMUL;
                end
            end
            S_QMUL: begin
                n_state = S_QSUB;
            end
            S_QSUB: begin
                if (!r_phase) begin
                    n_sum   = t_data'(0) - part;
                    n_phase = 1'b1;
                    n_idx   = {1'b0, r_hi};
                    n_state = S_QRD;
                end else begin
                    n_sum   = r_sum + part;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.range_sum = r_sum;
                    n_out.status    = r_bad ? C_STS_BAD : C_STS_DONE;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_phase <= n_phase;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_val   <= n_val;
        r_q1    <= n_q1;
        r_q2    <= n_q2;
        r_sum   <= n_sum;
        r_bad   <= n_bad;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

// ----- sv/fwk_ram.sv -----
// ----------------------------------------------------------------------------
// fwk_ram
// One tree store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwk_ram import fwk_pkg::*; (
    input  wire      i_clk,
    input  t_ram_req i_req,
    output t_data    o_rdata
);

    t_data r_mem [C_SIZE];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/fwk_mul.sv -----
// ----------------------------------------------------------------------------
// fwk_mul
// Shared multiplier: low word of a 32x32 product, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwk_mul import fwk_pkg::*; (
    input  wire   i_clk,
    input  wire   i_en,
    input  t_data i_a,
    input  t_data i_b,
    output t_data o_prod
);

    t_data r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= t_data'(i_a * i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/fwk_chk.sv -----
// ----------------------------------------------------------------------------
// fwk_chk
// Port-level checks for the Fenwick range-add/range-sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fenwick_range_add_range_sum_assert.svh"

module fwk_chk import fwk_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_beat  i_in,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_beat o_out
);

    // one item in flight: the beat after an accept is stalled
    `FWK_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "second beat taken while busy")

    `FWK_ASSERT_SAME(a_bad_sum_zero, o_out_valid && (o_out.status == C_STS_BAD), o_out.range_sum == '0, "bad range with nonzero sum")

    `FWK_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "out beat dropped while stalled")

    `FWK_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out), "stalled out beat changed")

endmodule

bind fenwick_range_add_range_sum fwk_chk u_fwk_chk (.*);

`default_nettype wire

// ----- bench/fenwick_range_add_range_sum_test.sv -----
// ----------------------------------------------------------------------------
// fenwick_range_add_range_sum_test
// Drives range-add and range-sum beats into the Fenwick block through the
// valid/stall channels, with random gaps on both sides. A table of directed
// beats covers range extremes, wrapping values and bad ranges. Random beats
// follow. Results are compared with a local two-tree model or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fenwick_range_add_range_sum_test;
    import fwk_pkg::*;

    localparam int          N_PLAN   = 22;
    localparam int unsigned N_RANDOM = 400;
    localparam int unsigned LIMIT    = 200000;
    localparam int unsigned DRAIN    = 40;

    typedef struct packed {
        t_in_beat  item;
        logic      typed;
        t_out_beat want;
    } t_row;

    // typed rows carry their own answer, the rest go through the model
    localparam t_row PLAN [N_PLAN] = '{
        '{'{C_REQ_QUERY, 10'd1,    10'd1023, 32'h00000000}, 1'b1, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd1,    10'd1023, 32'h00000005}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1,    10'd1023, 32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd1,    10'd1,    32'h7fffffff}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd1023, 10'd1023, 32'h80000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd512,  10'd1023, 32'hffffffff}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd3,    10'd700,  32'h12345678}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1,    10'd1,    32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1023, 10'd1023, 32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd2,    10'd1022, 32'hffffffff}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd0,    10'd1023, 32'hffffffff}, 1'b1, '{32'h0, C_STS_BAD}},
        '{'{C_REQ_QUERY, 10'd0,    10'd0,    32'h00000000}, 1'b1, '{32'h0, C_STS_BAD}},
        '{'{C_REQ_ADD,   10'd1023, 10'd1,    32'h00000001}, 1'b1, '{32'h0, C_STS_BAD}},
        '{'{C_REQ_QUERY, 10'd600,  10'd599,  32'h00000000}, 1'b1, '{32'h0, C_STS_BAD}},
        '{'{C_REQ_ADD,   10'd512,  10'd512,  32'h00000001}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd512,  10'd512,  32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd511,  10'd513,  32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd1,    10'd1023, 32'h80000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1,    10'd1023, 32'h00000000}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_ADD,   10'd1022, 10'd1023, 32'h55555555}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1000, 10'd1023, 32'haaaaaaaa}, 1'b0, '{32'h0, C_STS_DONE}},
        '{'{C_REQ_QUERY, 10'd1023, 10'd1022, 32'h7fffffff}, 1'b1, '{32'h0, C_STS_BAD}}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    bit          steady = 1'b0;
    bit [31:0]   diff_nodes  [C_SIZE];
    bit [31:0]   wdiff_nodes [C_SIZE];
    t_out_beat   sum_q [$];
    int unsigned fails     = 0;
    int unsigned n_checked = 0;
    int unsigned n_add     = 0;
    int unsigned n_sum     = 0;
    int unsigned n_bad     = 0;

    fenwick_range_add_range_sum i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(99) < 30);
    end

    function automatic void tree_add(input bit weighted, input int unsigned idx,
                                     input bit [31:0] delta);
        int unsigned k;
        k = idx;
        while (k != 0 && k < C_SIZE) begin
            if (weighted) begin
                wdiff_nodes[k] += delta;
            end else begin
                diff_nodes[k] += delta;
            end
            k += k & (~k + 1);
        end
    endfunction

    function automatic bit [31:0] prefix_total(input int unsigned x);
        bit [31:0]   s_diff;
        bit [31:0]   s_wdiff;
        bit [31:0]   xw;
        int unsigned k;
        s_diff  = '0;
        s_wdiff = '0;
        xw      = x;
        k       = x;
        while (k != 0 && k < C_SIZE) begin
            s_diff  += diff_nodes[k];
            s_wdiff += wdiff_nodes[k];
            k -= k & (~k + 1);
        end
        return xw * s_diff - s_wdiff;
    endfunction

    function automatic t_out_beat apply_item(input t_in_beat b);
        t_out_beat r;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] v;
        lo = 32'(b.left);
        hi = 32'(b.right);
        v  = b.value;
        r.range_sum = '0;
        r.status    = C_STS_BAD;
        if (lo == 0 || lo > hi || hi > C_LAST) begin
            return r;
        end
        r.status = C_STS_DONE;
        if (b.req_type == C_REQ_ADD) begin
            tree_add(1'b0, lo, v);
            tree_add(1'b0, hi + 1, -v);
            tree_add(1'b1, lo, (lo - 1) * v);
            tree_add(1'b1, hi + 1, -(hi * v));
        end else begin
            r.range_sum = prefix_total(hi) - prefix_total(lo - 1);
        end
        return r;
    endfunction

    function automatic t_in_beat draw_item();
        t_in_beat    b;
        int unsigned a;
        int unsigned c;
        int unsigned t;
        b.req_type = $urandom_range(1) ? C_REQ_QUERY : C_REQ_ADD;
        case ($urandom_range(9))
            0: b.value = $urandom_range(16) - 8;
            1: b.value = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: b.value = $urandom;
        endcase
        t = $urandom_range(99);
        if (t < 4) begin
            a = 0;
            c = $urandom_range(C_LAST);
        end else if (t < 8) begin
            a = $urandom_range(C_LAST, 1);
            c = $urandom_range(a - 1, 0);
        end else begin
            if (t < 30) begin
                a = $urandom_range(C_LAST, 1);
                c = a + $urandom_range(3);
                if (c > C_LAST) c = C_LAST;
            end else if (t < 45) begin
                a = $urandom_range(1) ? 1 : $urandom_range(C_LAST, 1);
                c = $urandom_range(1) ? C_LAST : $urandom_range(C_LAST, 1);
            end else begin
                a = $urandom_range(C_LAST, 1);
                c = $urandom_range(C_LAST, 1);
            end
            if (a > c) begin
                t = a;
                a = c;
                c = t;
            end
        end
        b.left  = 10'(a);
        b.right = 10'(c);
        return b;
    endfunction

    task automatic push_item(input t_in_beat b, input bit typed, input t_out_beat typed_want);
        t_out_beat predicted;
        while (!steady && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_item(b);
        sum_q.push_back(typed ? typed_want : predicted);
        if (predicted.status == C_STS_BAD) n_bad++;
        else if (b.req_type == C_REQ_ADD) n_add++;
        else n_sum++;
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            n_checked++;
            if (sum_q.size() == 0) begin
                $error("result beat with nothing pending: range_sum %0d status %0d",
                       out_beat.range_sum, out_beat.status);
                fails++;
            end else begin
                want = sum_q.pop_front();
                if (out_beat.range_sum !== want.range_sum) begin
                    $error("range_sum: expected %0d, got %0d", want.range_sum,
                           out_beat.range_sum);
                    fails++;
                end
                if (out_beat.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_beat.status);
                    fails++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned n;
        n = 0;
        while (n < LIMIT) begin
            @(posedge clk);
            n++;
        end
        $display("timeout after %0d cycles, %0d results pending", LIMIT, sum_q.size());
        $display("fenwick_range_add_range_sum_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_in_beat    b;
        int unsigned good;
        bit          paused;
        good   = 0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_PLAN; r++) begin
            push_item(PLAN[r].item, PLAN[r].typed, PLAN[r].want);
        end

        while (good < N_RANDOM) begin
            steady = (good >= 200 && good < 300);
            if (good == 100 && !paused) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (sum_q.size() != 0);
            end
            b = draw_item();
            push_item(b, 1'b0, '0);
            if (b.left != 0 && b.left <= b.right) good++;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        do @(posedge clk); while (sum_q.size() != 0);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d range adds, %0d range sums, %0d bad ranges; %0d results compared",
                 n_add, n_sum, n_bad, n_checked);
        if (fails == 0) begin
            $display("fenwick_range_add_range_sum_test: done, clean");
        end else begin
            $display("fenwick_range_add_range_sum_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- fenwick_range_add_range_sum.f -----
+incdir+sv
sv/fwk_pkg.sv
sv/fwk_ram.sv
sv/fwk_mul.sv
sv/fenwick_range_add_range_sum.sv
sv/fwk_chk.sv
bench/fenwick_range_add_range_sum_test.sv
